// ===== design/whitespace_token_window_chunker_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef WHITESPACE_TOKEN_WINDOW_CHUNKER_UNIT_DEFINES_SVH
`define WHITESPACE_TOKEN_WINDOW_CHUNKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WTC_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("wtc checker: implication failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WTC_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("wtc checker: next-cycle implication failed");

`endif

// ===== design/wtc_pkg.sv =====
package wtc_pkg;

  localparam int DEF_MAX_WINDOW_TOKENS = 512;
  localparam int DEF_MAX_SECTION_BYTES = 1048576;
  localparam int DEFAULT_WINDOW        = 220;

  // x / 5 as (x * 3277) >> 14, exact for x below 16384
  localparam int DIV5_MUL   = 3277;
  localparam int DIV5_SHIFT = 14;

  localparam int BYTE_W  = 8;
  localparam int START_W = 20;
  localparam int END_W   = 21;
  localparam int CNT_W   = 10;
  localparam int CHUNK_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IW  = 3;
  localparam int WIN_CFG_W = 10;

  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'd32;
  localparam logic [BYTE_W-1:0] CH_WS_LO  = 8'd9;
  localparam logic [BYTE_W-1:0] CH_WS_HI  = 8'd13;

  typedef enum logic [CFG_IW-1:0] {
    CFG_WINDOW  = 3'd0,
    CFG_OVERLAP = 3'd1,
    CFG_TOK_LIM = 3'd2,
    CFG_DOC_LIM = 3'd3,
    CFG_EMB_LIM = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              first_of_document;
    logic              last_of_section;
  } in_word_t;

  typedef struct packed {
    logic               valid;
    logic [START_W-1:0] chunk_start;
    logic [END_W-1:0]   chunk_end;
    logic [CNT_W-1:0]   window_token_count;
    logic [CNT_W-1:0]   token_budget;
    logic [CHUNK_W-1:0] chunk_number;
    logic               section_done;
  } res_word_t;

endpackage

// ===== design/wtc_if.sv =====
interface wtc_in_if import wtc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              first_of_document;
  logic              last_of_section;

  modport source (output valid, text_byte, first_of_document, last_of_section, input ready);
  modport sink   (input valid, text_byte, first_of_document, last_of_section, output ready);
endinterface

interface wtc_out_if import wtc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [START_W-1:0] chunk_start;
  logic [END_W-1:0]   chunk_end;
  logic [CNT_W-1:0]   window_token_count;
  logic [CNT_W-1:0]   token_budget;
  logic [CHUNK_W-1:0] chunk_number;
  logic               section_done;

  modport source (output valid, chunk_start, chunk_end, window_token_count, token_budget,
                  chunk_number, section_done, input ready);
  modport sink   (input valid, chunk_start, chunk_end, window_token_count, token_budget,
                  chunk_number, section_done, output ready);
endinterface

// ===== design/whitespace_token_window_chunker_unit.sv =====
// A word taken into the input register is worked there by the section logic; its result
// word enters the result register as the byte advances, and is offered from then on.
// Throughput: one text byte per cycle unless the output stalls; the window start ring
// (one write, one read per cycle) and the per-byte token logic both keep pace with that.
// Reset: synchronous, rst_n low; section state, chunk index and settings return to
// defaults at once. The ring contents are not cleared. Settings apply to words taken
// after the write edge.
module whitespace_token_window_chunker_unit import wtc_pkg::*; #(
  parameter int MAX_WINDOW_TOKENS = DEF_MAX_WINDOW_TOKENS,
  parameter int MAX_SECTION_BYTES = DEF_MAX_SECTION_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  wtc_in_if.sink            in_ch,
  wtc_out_if.source         out_ch
);

  localparam int WBW = $clog2(MAX_WINDOW_TOKENS + 1);

  // Input register: holds one byte word for the section logic.
  logic      s1_v_r;
  in_word_t  s1_r;
  // Result register: parts the section logic from the output handshake.
  logic      out_v_r;
  res_word_t out_r;

  logic           adv;
  logic [WBW-1:0] budget, step;
  res_word_t      res;

  // Advance the held byte when the result register is free or being emptied.
  assign adv         = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_r.text_byte         <= in_ch.text_byte;
      s1_r.first_of_document <= in_ch.first_of_document;
      s1_r.last_of_section   <= in_ch.last_of_section;
    end
  end

  // Effective budget and window step, worked out from the settings and registered once.
  wtc_budget #(.MAX_WINDOW_TOKENS(MAX_WINDOW_TOKENS), .WBW(WBW)) u_budget (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .budget    (budget),
    .step      (step)
  );

  // Tokeniser, window tracking and ring of pending window starts.
  wtc_step #(
    .MAX_WINDOW_TOKENS (MAX_WINDOW_TOKENS),
    .MAX_SECTION_BYTES (MAX_SECTION_BYTES),
    .WBW               (WBW)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_w   (s1_r),
    .budget (budget),
    .step   (step),
    .res    (res)
  );

  // Load a fresh result on advance, drop the old one once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= res.valid;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.chunk_start        = out_r.chunk_start;
  assign out_ch.chunk_end          = out_r.chunk_end;
  assign out_ch.window_token_count = out_r.window_token_count;
  assign out_ch.token_budget       = out_r.token_budget;
  assign out_ch.chunk_number       = out_r.chunk_number;
  assign out_ch.section_done       = out_r.section_done;

endmodule

// ===== design/wtc_ring.sv =====
module wtc_ring import wtc_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WINDOW_TOKENS,
  parameter int AW    = 9,
  parameter int DW    = START_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_r;
  logic [DW-1:0] byp_data_r;
  logic          byp_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r       <= mem[raddr];
    byp_r      <= we && (waddr == raddr);
    byp_data_r <= wdata;
  end

  // write-through on a same-address read
  assign rdata = byp_r ? byp_data_r : rd_r;

endmodule

// ===== design/wtc_budget.sv =====
module wtc_budget import wtc_pkg::*; #(
  parameter int MAX_WINDOW_TOKENS = DEF_MAX_WINDOW_TOKENS,
  parameter int WBW = $clog2(MAX_WINDOW_TOKENS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic [WBW-1:0]    budget,
  output logic [WBW-1:0]    step
);

  localparam int RST_B = (DEFAULT_WINDOW > MAX_WINDOW_TOKENS) ? MAX_WINDOW_TOKENS
                                                              : DEFAULT_WINDOW;
  localparam int PW = WBW + 12;

  logic [WIN_CFG_W-1:0] win_r, ovl_r;
  logic [CFG_W-1:0]     tok_lim_r, doc_lim_r, emb_lim_r;
  logic [WBW-1:0]       budget_r, step_r;

  logic [WIN_CFG_W-1:0] w_def;
  logic [WBW-1:0]       w_sat, w_div5, ov_sel, b_min, ov2;
  logic [PW-1:0]        prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= WIN_CFG_W'(DEFAULT_WINDOW);
      ovl_r     <= '0;
      tok_lim_r <= '0;
      doc_lim_r <= '0;
      emb_lim_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WINDOW:  win_r     <= cfg_wdata[WIN_CFG_W-1:0];
        CFG_OVERLAP: ovl_r     <= cfg_wdata[WIN_CFG_W-1:0];
        CFG_TOK_LIM: tok_lim_r <= cfg_wdata;
        CFG_DOC_LIM: doc_lim_r <= cfg_wdata;
        CFG_EMB_LIM: emb_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_def = (win_r == '0) ? WIN_CFG_W'(DEFAULT_WINDOW) : win_r;
    if (CFG_W'(w_def) > CFG_W'(MAX_WINDOW_TOKENS)) begin
      w_sat = WBW'(MAX_WINDOW_TOKENS);
    end else begin
      w_sat = WBW'(w_def);
    end
    prod   = PW'(w_sat) * PW'(DIV5_MUL);
    w_div5 = WBW'(prod >> DIV5_SHIFT);
    ov_sel = (CFG_W'(ovl_r) >= CFG_W'(w_sat)) ? w_div5 : WBW'(ovl_r);
    b_min  = w_sat;
    if (tok_lim_r != '0 && tok_lim_r < CFG_W'(b_min)) b_min = WBW'(tok_lim_r);
    if (doc_lim_r != '0 && doc_lim_r < CFG_W'(b_min)) b_min = WBW'(doc_lim_r);
    if (emb_lim_r != '0 && emb_lim_r < CFG_W'(b_min)) b_min = WBW'(emb_lim_r);
    if (b_min == '0) b_min = WBW'(1);
  end

  assign ov2 = (ov_sel > b_min - WBW'(1)) ? b_min - WBW'(1) : ov_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= WBW'(RST_B);
      step_r   <= WBW'(RST_B);
    end else begin
      budget_r <= b_min;
      step_r   <= b_min - ov2;
    end
  end

  assign budget = budget_r;
  assign step   = step_r;

endmodule

// ===== design/wtc_step.sv =====
module wtc_step import wtc_pkg::*; #(
  parameter int MAX_WINDOW_TOKENS = DEF_MAX_WINDOW_TOKENS,
  parameter int MAX_SECTION_BYTES = DEF_MAX_SECTION_BYTES,
  parameter int WBW = $clog2(MAX_WINDOW_TOKENS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  in_word_t       in_w,
  input  logic [WBW-1:0] budget,
  input  logic [WBW-1:0] step,
  output res_word_t      res
);

  localparam int OW  = $clog2(MAX_SECTION_BYTES + 1);
  localparam int SW  = $clog2(MAX_SECTION_BYTES);
  localparam int TW  = OW;
  localparam int RD  = MAX_WINDOW_TOKENS;
  localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
  localparam int FW  = $clog2(RD + 1);

  logic [OW-1:0]      boff_r, boff_nxt, lte_r, lte_nxt;
  logic [TW-1:0]      tseen_r, tseen_nxt, oldest_r, oldest_nxt, next_r, next_nxt;
  logic               inside_r, inside_nxt, ended_r, ended_nxt;
  logic [RAW-1:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;

  logic               ws, start_tok, push_cond, push, end_tok, win, flush, ended_b;
  logic [SW-1:0]      s, head_q, head_ent;
  logic [OW:0]        p1;
  logic [OW-1:0]      e, lte_b;
  logic [TW-1:0]      tseen_b, oldest_a, next_a, diff;
  logic [FW-1:0]      fill_a;
  logic [WBW-1:0]     cnt;
  logic [CHUNK_W-1:0] cc_base;

  function automatic logic [RAW-1:0] ring_inc(input logic [RAW-1:0] a);
    return (a == RAW'(RD - 1)) ? '0 : a + RAW'(1);
  endfunction

  wtc_ring #(.DEPTH(RD), .AW(RAW), .DW(SW)) u_ring (
    .clk   (clk),
    .we    (adv && push),
    .waddr (tail_r),
    .wdata (s),
    .raddr (head_nxt),
    .rdata (head_q)
  );

  always_comb begin
    ws = (in_w.text_byte == CH_SPACE) ||
         (in_w.text_byte >= CH_WS_LO && in_w.text_byte <= CH_WS_HI);
    cc_base = in_w.first_of_document ? '0 : chunk_r;

    s = (boff_r > OW'(MAX_SECTION_BYTES - 1)) ? SW'(MAX_SECTION_BYTES - 1) : SW'(boff_r);

    // open a window on a token start one step after the last
    start_tok = !ws && !inside_r;
    push_cond = start_tok && (tseen_r >= next_r);
    push      = push_cond && (fill_r < FW'(RD));
    fill_a    = fill_r + FW'(push);
    oldest_a  = (push && fill_r == '0) ? tseen_r : oldest_r;
    next_a    = push_cond ? tseen_r + TW'(step) : next_r;
    head_ent  = (fill_r == '0) ? s : head_q;

    end_tok = (!ws && in_w.last_of_section) || (ws && inside_r);
    p1      = {1'b0, boff_r} + (OW + 1)'(1);
    if (!ws) begin
      e = (p1 > (OW + 1)'(MAX_SECTION_BYTES)) ? OW'(MAX_SECTION_BYTES) : OW'(p1);
    end else begin
      e = boff_r;
    end
    tseen_b = tseen_r + TW'(end_tok);
    win     = end_tok && (fill_a != '0) &&
              ({1'b0, tseen_b} >= {1'b0, oldest_a} + (TW + 1)'(budget));
    ended_b = end_tok ? win : ended_r;
    lte_b   = end_tok ? e : lte_r;

    flush = in_w.last_of_section && !win && (tseen_b != '0) && !ended_b && (fill_a != '0);
    diff  = tseen_b - oldest_a;
    cnt   = (diff > TW'(budget)) ? budget : WBW'(diff);

    res.valid              = win || flush;
    res.chunk_start        = START_W'(head_ent);
    res.chunk_end          = END_W'(win ? e : lte_b);
    res.window_token_count = CNT_W'(win ? budget : cnt);
    res.token_budget       = CNT_W'(budget);
    res.chunk_number       = cc_base;
    res.section_done       = in_w.last_of_section;

    boff_nxt   = boff_r;
    lte_nxt    = lte_r;
    tseen_nxt  = tseen_r;
    oldest_nxt = oldest_r;
    next_nxt   = next_r;
    inside_nxt = inside_r;
    ended_nxt  = ended_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    chunk_nxt  = chunk_r;
    if (adv) begin
      chunk_nxt = cc_base + CHUNK_W'(res.valid);
      if (in_w.last_of_section) begin
        boff_nxt   = '0;
        lte_nxt    = '0;
        tseen_nxt  = '0;
        oldest_nxt = '0;
        next_nxt   = '0;
        inside_nxt = 1'b0;
        ended_nxt  = 1'b0;
        head_nxt   = '0;
        tail_nxt   = '0;
        fill_nxt   = '0;
      end else begin
        boff_nxt   = (boff_r < OW'(MAX_SECTION_BYTES)) ? boff_r + OW'(1) : boff_r;
        lte_nxt    = lte_b;
        tseen_nxt  = tseen_b;
        next_nxt   = next_a;
        inside_nxt = !ws;
        ended_nxt  = ended_b;
        tail_nxt   = push ? ring_inc(tail_r) : tail_r;
        head_nxt   = win ? ring_inc(head_r) : head_r;
        fill_nxt   = fill_a - FW'(win);
        oldest_nxt = win ? oldest_a + TW'(step) : oldest_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boff_r   <= '0;
      lte_r    <= '0;
      tseen_r  <= '0;
      oldest_r <= '0;
      next_r   <= '0;
      inside_r <= 1'b0;
      ended_r  <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
      chunk_r  <= '0;
    end else begin
      boff_r   <= boff_nxt;
      lte_r    <= lte_nxt;
      tseen_r  <= tseen_nxt;
      oldest_r <= oldest_nxt;
      next_r   <= next_nxt;
      inside_r <= inside_nxt;
      ended_r  <= ended_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      chunk_r  <= chunk_nxt;
    end
  end

endmodule

// ===== design/wtc_checker.sv =====
`include "whitespace_token_window_chunker_unit_defines.svh"

module wtc_checker import wtc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CNT_W-1:0] out_count,
  input logic [CNT_W-1:0] out_budget
);

  `WTC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_count) && $stable(out_budget))
  `WTC_ASSERT_IMP(a_in_stall, !in_ready, out_valid && !out_ready)
  `WTC_ASSERT_IMP(a_budget_nz, out_valid, out_budget != '0)
  `WTC_ASSERT_IMP(a_count_le, out_valid && in_valid, out_count <= out_budget)

endmodule

bind whitespace_token_window_chunker_unit wtc_checker u_wtc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_count  (out_ch.window_token_count),
  .out_budget (out_ch.token_budget)
);

// ===== dv/tb_whitespace_token_window_chunker_unit.sv =====
`timescale 1ns / 1ps

module tb_whitespace_token_window_chunker_unit import wtc_pkg::*; ();

  localparam int WINDOW_MAX    = DEF_MAX_WINDOW_TOKENS;
  localparam int SECTION_MAX   = DEF_MAX_SECTION_BYTES;
  localparam int RING_AW       = $clog2(DEF_MAX_WINDOW_TOKENS);
  localparam int OVERLAP_DIV   = 5;
  localparam int DRAIN_CYCLES  = 8;      // idle time after the queues empty
  localparam int PHASE_ITEMS   = 36;
  localparam int HOLD_CYCLES   = 90;
  localparam int CYCLE_LIMIT   = 200000;

  // One expected chunk as the result channel carries it.
  typedef struct {
    bit [START_W-1:0] start_off;
    bit [END_W-1:0]   end_off;
    bit [CNT_W-1:0]   tokens;
    bit [CNT_W-1:0]   budget;
    bit [CHUNK_W-1:0] number;
    bit               done;
  } chunk_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  wtc_in_if  in_if ();
  wtc_out_if out_if ();

  whitespace_token_window_chunker_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // Text bytes still to be offered, and chunks the block still owes us.
  in_word_t pending_words [$];
  chunk_t   chunks_due [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_armed;
  bit          receiver_hold;
  int unsigned mismatches;
  int unsigned cycle_count;

  // Chunker settings as last written, and the budget and stride they give.
  bit [WIN_CFG_W-1:0] set_window;
  bit [WIN_CFG_W-1:0] set_overlap;
  bit [CFG_W-1:0]     set_tok_lim;
  bit [CFG_W-1:0]     set_doc_lim;
  bit [CFG_W-1:0]     set_emb_lim;
  int unsigned        budget_eff;
  int unsigned        stride;

  // Section state of the chunker.
  bit [START_W-1:0]   start_ring [WINDOW_MAX];
  bit [RING_AW-1:0]   ring_rd;
  bit [RING_AW-1:0]   ring_wr;
  int unsigned        ring_count;
  int unsigned        byte_pos;
  int unsigned        tokens_done;
  int unsigned        first_pending_tok;
  int unsigned        next_start_tok;
  int unsigned        last_tok_end;
  bit                 in_token;
  bit                 closed_on_window;
  bit [CHUNK_W-1:0]   chunk_no;

  // Budget: default and saturate the window, fall back to a fifth for an oversized
  // overlap, clamp by every nonzero limit, then keep the overlap below the budget.
  function automatic void derive_budget();
    int unsigned w;
    int unsigned ov;
    int unsigned b;
    w  = set_window;
    ov = set_overlap;
    if (w == 0) w = DEFAULT_WINDOW;
    if (w > WINDOW_MAX) w = WINDOW_MAX;
    if (ov >= w) ov = w / OVERLAP_DIV;
    b = w;
    if (set_tok_lim != 0 && set_tok_lim < b) b = set_tok_lim;
    if (set_doc_lim != 0 && set_doc_lim < b) b = set_doc_lim;
    if (set_emb_lim != 0 && set_emb_lim < b) b = set_emb_lim;
    if (b < 1) b = 1;
    if (ov > b - 1) ov = b - 1;
    budget_eff = b;
    stride     = b - ov;
  endfunction

  function automatic void clear_section();
    ring_rd           = '0;
    ring_wr           = '0;
    ring_count        = 0;
    byte_pos          = 0;
    tokens_done       = 0;
    first_pending_tok = 0;
    next_start_tok    = 0;
    last_tok_end      = 0;
    in_token          = 1'b0;
    closed_on_window  = 1'b0;
  endfunction

  function automatic void emit_chunk(int unsigned s, int unsigned e, int unsigned n, bit done);
    chunk_t c;
    c.start_off = s[START_W-1:0];
    c.end_off   = e[END_W-1:0];
    c.tokens    = n[CNT_W-1:0];
    c.budget    = budget_eff[CNT_W-1:0];
    c.number    = chunk_no;
    c.done      = done;
    chunks_due  = {chunks_due, c};
    chunk_no++;
  endfunction

  // A token ends at offset e; give the oldest window if it now holds a full budget.
  function automatic bit close_token(int unsigned e, bit done);
    tokens_done++;
    last_tok_end = e;
    in_token     = 1'b0;
    if (ring_count > 0 && tokens_done >= first_pending_tok + budget_eff) begin
      emit_chunk(start_ring[ring_rd], e, budget_eff, done);
      ring_rd++;
      ring_count--;
      first_pending_tok += stride;
      closed_on_window = 1'b1;
      return 1'b1;
    end
    closed_on_window = 1'b0;
    return 1'b0;
  endfunction

  // Advance the chunker by one accepted text word.
  function automatic void predict_word(in_word_t w);
    bit          ws;
    bit          gave;
    int unsigned p;
    int unsigned s;
    int unsigned e;
    int unsigned cnt;
    ws   = (w.text_byte == CH_SPACE) ||
           (w.text_byte >= CH_WS_LO && w.text_byte <= CH_WS_HI);
    gave = 1'b0;
    if (w.first_of_document) chunk_no = '0;
    p = (byte_pos > SECTION_MAX) ? SECTION_MAX : byte_pos;

    if (!ws) begin
      if (!in_token) begin
        // a token opens: it may also open a window, one stride after the last
        s = (p > SECTION_MAX - 1) ? SECTION_MAX - 1 : p;
        in_token = 1'b1;
        if (tokens_done >= next_start_tok) begin
          if (ring_count < WINDOW_MAX) begin
            if (ring_count == 0) first_pending_tok = tokens_done;
            start_ring[ring_wr] = s[START_W-1:0];
            ring_wr++;
            ring_count++;
          end
          next_start_tok = tokens_done + stride;
        end
      end
      if (w.last_of_section) begin
        e = (p + 1 > SECTION_MAX) ? SECTION_MAX : p + 1;
        gave = close_token(e, 1'b1);
      end
    end else if (in_token) begin
      gave = close_token(p, w.last_of_section);
    end

    if (w.last_of_section) begin
      // flush the earliest unfinished window unless the section ended on a full one
      if (!gave && tokens_done > 0 && !closed_on_window && ring_count > 0) begin
        cnt = tokens_done - first_pending_tok;
        if (cnt > budget_eff) cnt = budget_eff;
        emit_chunk(start_ring[ring_rd], last_tok_end, cnt, 1'b1);
      end
      clear_section();
    end else if (byte_pos < SECTION_MAX) begin
      byte_pos++;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void push_word(bit [BYTE_W-1:0] b, bit first, bit last);
    in_word_t w;
    w.text_byte         = b;
    w.first_of_document = first;
    w.last_of_section   = last;
    pending_words       = {pending_words, w};
  endfunction

  // Random section: mostly printable tokens split by every kind of whitespace,
  // with the odd arbitrary byte thrown in.
  task automatic queue_section(int unsigned len, bit new_doc);
    int unsigned     i;
    int unsigned     roll;
    int unsigned     k;
    bit [BYTE_W-1:0] b;
    for (i = 0; i < len; i++) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        b = BYTE_W'($urandom_range(255));
      end else if (roll < 36) begin
        k = $urandom_range(5);
        b = (k == 5) ? CH_SPACE : CH_WS_LO + BYTE_W'(k);
      end else begin
        b = BYTE_W'($urandom_range(8'h7e, 8'h21));
      end
      push_word(b, (i == 0 && new_doc) || ($urandom_range(99) < 2), i == len - 1);
    end
  endtask

  // Fill one phase with sections; most short, a few long.
  task automatic queue_phase(int unsigned items);
    int unsigned queued;
    int unsigned len;
    queued = 0;
    while (queued < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 40) : $urandom_range(24, 1);
      queue_section(len, $urandom_range(3) == 0);
      queued += len;
    end
  endtask

  task automatic write_setting(cfg_idx_t idx, int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_WINDOW:  set_window  = value[WIN_CFG_W-1:0];
      CFG_OVERLAP: set_overlap = value[WIN_CFG_W-1:0];
      CFG_TOK_LIM: set_tok_lim = value[CFG_W-1:0];
      CFG_DOC_LIM: set_doc_lim = value[CFG_W-1:0];
      CFG_EMB_LIM: set_emb_lim = value[CFG_W-1:0];
      default: ;
    endcase
    derive_budget();
  endtask

  task automatic apply_settings(int unsigned win, int unsigned ovl, int unsigned tok,
                                int unsigned doc, int unsigned emb);
    write_setting(CFG_WINDOW, win);
    write_setting(CFG_OVERLAP, ovl);
    write_setting(CFG_TOK_LIM, tok);
    write_setting(CFG_DOC_LIM, doc);
    write_setting(CFG_EMB_LIM, emb);
    // settings pass the setting and budget registers; wait for them to settle
    repeat (4) @(negedge clk);
  endtask

  // Wait until every word is in and every chunk out, then idle so the
  // pipeline can drain.
  task automatic settle_idle();
    while (pending_words.size() != 0 || chunks_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Word driver: hold the offered word until taken, predict on acceptance,
  // then offer the next one or idle at the phase's rate.
  always @(posedge clk) begin : word_driver
    if (!rst_n) begin
      in_if.valid             <= 1'b0;
      in_if.text_byte         <= '0;
      in_if.first_of_document <= 1'b0;
      in_if.last_of_section   <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_word(pending_words.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid             <= 1'b1;
          in_if.text_byte         <= pending_words[0].text_byte;
          in_if.first_of_document <= pending_words[0].first_of_document;
          in_if.last_of_section   <= pending_words[0].last_of_section;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Chunk monitor: check each taken word against the oldest expected chunk,
  // then choose whether to stall the next cycle.
  always @(posedge clk) begin : chunk_monitor
    chunk_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (chunks_due.size() == 0) begin
          report_mismatch($sformatf("unexpected chunk start %0d end %0d count %0d",
                                    out_if.chunk_start, out_if.chunk_end,
                                    out_if.window_token_count));
        end else begin
          want = chunks_due.pop_front();
          if (out_if.chunk_start !== want.start_off)
            report_mismatch($sformatf("chunk %0d chunk_start %0d, want %0d", want.number,
                                      out_if.chunk_start, want.start_off));
          if (out_if.chunk_end !== want.end_off)
            report_mismatch($sformatf("chunk %0d chunk_end %0d, want %0d", want.number,
                                      out_if.chunk_end, want.end_off));
          if (out_if.window_token_count !== want.tokens)
            report_mismatch($sformatf("chunk %0d window_token_count %0d, want %0d",
                                      want.number, out_if.window_token_count, want.tokens));
          if (out_if.token_budget !== want.budget)
            report_mismatch($sformatf("chunk %0d token_budget %0d, want %0d", want.number,
                                      out_if.token_budget, want.budget));
          if (out_if.chunk_number !== want.number)
            report_mismatch($sformatf("chunk_number %0d, want %0d", out_if.chunk_number,
                                      want.number));
          if (out_if.section_done !== want.done)
            report_mismatch($sformatf("chunk %0d section_done %0b, want %0b", want.number,
                                      out_if.section_done, want.done));
        end
      end
      out_if.ready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the driver keeps pushing words
  // and the block backs up into its input.
  initial begin : receiver_hold_off
    receiver_hold = 1'b0;
    wait (hold_armed);
    @(negedge clk);
    receiver_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    receiver_hold = 1'b0;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] timeout with %0d words unsent, %0d chunks outstanding", $realtime,
             pending_words.size(), chunks_due.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_cfg [0:6][0:4];
    int unsigned phase;
    phase_cfg = '{'{4, 1, 0, 0, 0},            // budget 4, stride 3
                  '{1, 0, 0, 0, 0},            // one token per window
                  '{1023, 1023, 5, 0, 0},      // saturated window, tokenizer caps to 5
                  '{0, 0, 0, 0, 0},            // default budget of 220
                  '{6, 2, 65535, 3, 0},        // document limit wins, stride 1
                  '{8, 8, 0, 0, 4},            // oversized overlap falls back to a fifth
                  '{5, 3, 0, 65535, 65535}};   // limits at their top

    // Hold every input at a known value from time zero.
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_index                = CFG_WINDOW;
    cfg_wdata                = '0;
    send_idle_pct            = 0;
    recv_stall_pct           = 0;
    hold_armed               = 1'b0;
    mismatches               = 0;

    set_window  = DEFAULT_WINDOW;
    set_overlap = '0;
    set_tok_lim = '0;
    set_doc_lim = '0;
    set_emb_lim = '0;
    chunk_no    = '0;
    clear_section();
    derive_budget();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed: budget 3, no overlap.
    apply_settings(3, 0, 0, 0, 0);

    // Section of whitespace only, every whitespace code: no chunk.
    push_word(CH_SPACE, 1'b1, 1'b0);
    push_word(CH_WS_LO, 1'b0, 1'b0);
    push_word(8'd10, 1'b0, 1'b0);
    push_word(8'd11, 1'b0, 1'b0);
    push_word(8'd12, 1'b0, 1'b0);
    push_word(CH_WS_HI, 1'b0, 1'b1);

    // Window fills on the third token, then trailing whitespace closes the
    // section with nothing further. Byte extremes double as token text.
    push_word(8'h00, 1'b0, 1'b0);
    push_word(8'hff, 1'b0, 1'b0);
    push_word(CH_SPACE, 1'b0, 1'b0);
    push_word("c", 1'b0, 1'b0);
    push_word(CH_WS_HI, 1'b0, 1'b0);
    push_word("d", 1'b0, 1'b0);
    push_word(8'h80, 1'b0, 1'b0);
    push_word(CH_SPACE, 1'b0, 1'b0);
    push_word(CH_SPACE, 1'b0, 1'b1);

    // Shrink the budget halfway through a section; the open window then completes
    // on the next token end, and the last byte, inside a token, flushes a new one.
    push_word("x", 1'b1, 1'b0);
    push_word(CH_SPACE, 1'b0, 1'b0);
    push_word("y", 1'b0, 1'b0);
    push_word(CH_SPACE, 1'b0, 1'b0);
    settle_idle();
    write_setting(CFG_WINDOW, 2);
    repeat (4) @(negedge clk);
    push_word("z", 1'b0, 1'b0);
    push_word(CH_WS_LO, 1'b0, 1'b0);
    push_word("w", 1'b0, 1'b1);
    settle_idle();

    // Random phases: walk the settings table, then one random set, cycling through the idle modes.
    for (phase = 0; phase < 8; phase++) begin
      if (phase < 7) begin
        apply_settings(phase_cfg[phase][0], phase_cfg[phase][1], phase_cfg[phase][2],
                       phase_cfg[phase][3], phase_cfg[phase][4]);
      end else begin
        apply_settings($urandom_range(12, 1), $urandom_range(14),
                       ($urandom_range(1) == 1) ? $urandom_range(9, 1) : 0,
                       ($urandom_range(1) == 1) ? $urandom_range(65535) : 0,
                       ($urandom_range(1) == 1) ? $urandom_range(9, 1) : 0);
      end
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      queue_phase(PHASE_ITEMS);
      settle_idle();
    end

    // Back-pressure: budget 2 gives a chunk on nearly every token; block the
    // receiver for a long stretch while words keep coming.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_settings(2, 1, 0, 0, 0);
    hold_armed = 1'b1;
    queue_phase(PHASE_ITEMS);
    settle_idle();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
